>>> design/hmpd_pkg.sv
// Shared types and constants for the hold-and-modify pixel decoder.
package hmpd_pkg;

    localparam int CODE_W       = 8;
    localparam int PAL_DEPTH    = 1 << CODE_W;
    localparam int PAL_W        = 16;
    localparam int OUT_W        = 16;
    localparam int THRESH_W     = 9;
    localparam int REQ_W        = 2;
    localparam int COLOR_BITS_D = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(256);

    localparam logic [REQ_W-1:0] REQ_PALETTE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIXEL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FRAME   = 2'd2;

    // Control carried with a request into the color stage.
    typedef struct packed {
        logic pixel;
        logic frame;
        logic row_start;
        logic relative;
    } s1_ctl_t;

endpackage

>>> design/hmpd_palette.sv
// Palette memory: one write port, one registered read port.
module hmpd_palette (
    input  logic                         clk,
    input  logic                         we,
    input  logic [hmpd_pkg::CODE_W-1:0]  waddr,
    input  logic [hmpd_pkg::PAL_W-1:0]   wdata,
    input  logic                         re,
    input  logic [hmpd_pkg::CODE_W-1:0]  raddr,
    output logic [hmpd_pkg::PAL_W-1:0]   rdata
);
    import hmpd_pkg::*;

    logic [PAL_W-1:0] mem [PAL_DEPTH];
    logic [PAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/hmpd_color.sv
// Color stage: holds the running and row-first colors and forms the next color.
module hmpd_color #(
    parameter int COLOR_BITS = hmpd_pkg::COLOR_BITS_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  hmpd_pkg::s1_ctl_t           ctl,
    input  logic [hmpd_pkg::PAL_W-1:0]  entry,
    output logic [hmpd_pkg::OUT_W-1:0]  color_out
);
    import hmpd_pkg::*;

    logic [COLOR_BITS-1:0]         held_color_reg;
    logic [COLOR_BITS-1:0]         held_color_next;
    logic [COLOR_BITS-1:0]         row_first_reg;
    logic [COLOR_BITS-1:0]         row_first_next;
    logic [COLOR_BITS+PAL_W-1:0]   entry_wide;
    logic [COLOR_BITS-1:0]         entry_c;
    logic [COLOR_BITS-1:0]         prev_color;
    logic [COLOR_BITS-1:0]         new_color;
    logic [COLOR_BITS+OUT_W-1:0]   out_wide;

    // Fit the 16-bit palette entry to the working color width.
    assign entry_wide = {{COLOR_BITS{1'b0}}, entry};
    assign entry_c    = entry_wide[COLOR_BITS-1:0];

    assign prev_color = ctl.row_start ? row_first_reg : held_color_reg;
    assign new_color  = ctl.relative ? prev_color + entry_c : entry_c;

    assign out_wide  = {{OUT_W{1'b0}}, new_color};
    assign color_out = out_wide[OUT_W-1:0];

    always_comb
    begin
        held_color_next = held_color_reg;
        row_first_next  = row_first_reg;
        if (advance && ctl.pixel)
        begin
            held_color_next = new_color;
            if (ctl.row_start)
            begin
                row_first_next = new_color;
            end
        end
        else if (advance && ctl.frame)
        begin
            row_first_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_color_reg <= '0;
            row_first_reg  <= '0;
        end
        else
        begin
            held_color_reg <= held_color_next;
            row_first_reg  <= row_first_next;
        end
    end

endmodule

>>> design/hold_and_modify_pixel_decoder.sv
// Top level of the hold-and-modify pixel decoder.
// A pixel request is registered into the palette read port and color-stage control,
// then its color into the output register. Throughput: one request per cycle while
// pix_stall does not hold the output; the palette read port and color add loop allow it.
// Reset: control and held colors clear and the threshold loads 256 at once; palette
// contents stay undefined until written.
module hold_and_modify_pixel_decoder #(
    parameter int COLOR_BITS = hmpd_pkg::COLOR_BITS_D
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hmpd_pkg::THRESH_W-1:0]  cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [hmpd_pkg::REQ_W-1:0]     req_type,
    input  logic [hmpd_pkg::CODE_W-1:0]    code,
    input  logic [hmpd_pkg::PAL_W-1:0]     palette_value,
    input  logic                           row_start,
    output logic                           pix_valid,
    input  logic                           pix_stall,
    output logic [hmpd_pkg::OUT_W-1:0]     pixel_color
);
    import hmpd_pkg::*;

    logic [THRESH_W-1:0] threshold_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    s1_ctl_t             s1_ctl_reg;
    s1_ctl_t             s1_ctl_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_W-1:0]    out_color_reg;
    logic [OUT_W-1:0]    out_color_next;
    logic                accept;
    logic                advance;
    logic [PAL_W-1:0]    entry;
    logic [OUT_W-1:0]    color_out;

    assign advance   = s1_valid_reg && !(out_valid_reg && pix_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_data;
        end
    end

    hmpd_palette u_palette (
        .clk   (clk),
        .we    (accept && (req_type == REQ_PALETTE)),
        .waddr (code),
        .wdata (palette_value),
        .re    (accept),
        .raddr (code),
        .rdata (entry)
    );

    always_comb
    begin
        s1_ctl_next           = s1_ctl_reg;
        s1_valid_next         = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next         = 1'b1;
            s1_ctl_next.pixel     = (req_type == REQ_PIXEL);
            s1_ctl_next.frame     = (req_type == REQ_FRAME);
            s1_ctl_next.row_start = row_start;
            s1_ctl_next.relative  = ({1'b0, code} >= threshold_reg);
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    hmpd_color #(
        .COLOR_BITS (COLOR_BITS)
    ) u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (s1_ctl_reg),
        .entry     (entry),
        .color_out (color_out)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_color_next = out_color_reg;
        if (advance && s1_ctl_reg.pixel)
        begin
            out_valid_next = 1'b1;
            out_color_next = color_out;
        end
        else if (!pix_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_ctl_reg    <= s1_ctl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_color_reg <= out_color_next;
    end

    assign pix_valid   = out_valid_reg;
    assign pixel_color = out_color_reg;

    // Input is held back only by a request parked in the color stage.
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg)
        else $error("request stalled with empty color stage");

    // A pixel leaving the color stage lands in the output register.
    a_pixel_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_ctl_reg.pixel) |=> pix_valid)
        else $error("pixel lost between color stage and output");

    // Non-pixel requests never create a result.
    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        (!pix_valid && !(advance && s1_ctl_reg.pixel)) |=> !pix_valid)
        else $error("result without a pixel request");

endmodule

>>> verif/testbench.sv
// Testbench for the hold-and-modify pixel decoder: scoreboard, stimulus and result checks.
module testbench;

    import hmpd_pkg::*;

    localparam int COLOR_W = COLOR_BITS_D;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_PCT = 16;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 160;

    // Tracks palette, carried colors and threshold; queues the colors still owed.
    class pixel_color_board;
        logic [PAL_W-1:0]    palette [PAL_DEPTH];
        logic [COLOR_W-1:0]  held_color;
        logic [COLOR_W-1:0]  row_first_color;
        logic [THRESH_W-1:0] threshold;
        logic [OUT_W-1:0]    pending_colors [$];
        int                  errors;

        function new();
            held_color = '0;
            row_first_color = '0;
            threshold = THRESH_RESET;
            errors = 0;
        endfunction

        function void absorb_request(input logic [REQ_W-1:0] kind,
                                     input logic [CODE_W-1:0] idx,
                                     input logic [PAL_W-1:0] value,
                                     input logic first_in_row);
            logic [COLOR_W-1:0] entry;
            logic [COLOR_W-1:0] base;
            case (kind)
                REQ_PALETTE: palette[idx] = value;
                REQ_FRAME: row_first_color = '0;
                REQ_PIXEL:
                begin
                    entry = COLOR_W'(palette[idx]);
                    base = first_in_row ? row_first_color : held_color;
                    if ({1'b0, idx} >= threshold)
                        held_color = base + entry;
                    else
                        held_color = entry;
                    if (first_in_row)
                        row_first_color = held_color;
                    pending_colors.push_back(held_color[OUT_W-1:0]);
                end
                default: ;
            endcase
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_color(input logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_colors.size() == 0)
            begin
                report($sformatf("color %h with no pixel request outstanding", got));
                return;
            end
            want = pending_colors.pop_front();
            if (got !== want)
                report($sformatf("pixel_color %h, predicted %h", got, want));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [THRESH_W-1:0] cfg_data = '0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [REQ_W-1:0]    req_type = REQ_PALETTE;
    logic [CODE_W-1:0]   code = '0;
    logic [PAL_W-1:0]    palette_value = '0;
    logic                row_start = 1'b0;
    logic                pix_valid;
    logic                pix_stall = 1'b0;
    logic [OUT_W-1:0]    pixel_color;

    pixel_color_board board;
    bit                  entry_loaded [PAL_DEPTH];
    bit                  steady = 1'b0;
    bit                  hold_request = 1'b0;
    int                  hold_left = 0;
    int                  row_left = 0;
    logic                color_taken;
    logic [OUT_W-1:0]    color_seen;

    hold_and_modify_pixel_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .code          (code),
        .palette_value (palette_value),
        .row_start     (row_start),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pixel_color   (pixel_color)
    );

    always #2 clk = ~clk;

    initial
    begin
        #800000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when asked for one.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            pix_stall <= 1'b1;
            hold_left--;
        end
        else
            pix_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Handshake state is stable between negedge and the next posedge.
    always
    begin
        @(negedge clk);
        color_taken = (pix_valid === 1'b1) && !pix_stall;
        color_seen = pixel_color;
        @(posedge clk);
        if (color_taken)
            board.compare_color(color_seen);
    end

    // Called just after a rising edge; leaves req_valid high for the next request.
    task send_request(input logic [REQ_W-1:0] kind, input logic [CODE_W-1:0] idx,
                      input logic [PAL_W-1:0] value, input logic first_in_row);
        bit taken;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_type <= kind;
        code <= idx;
        palette_value <= value;
        row_start <= first_in_row;
        req_valid <= 1'b1;
        if (kind == REQ_PALETTE)
            entry_loaded[idx] = 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        board.absorb_request(kind, idx, value, first_in_row);
    endtask

    task drain_results;
        int waited;
        req_valid <= 1'b0;
        waited = 0;
        while (board.pending_colors.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        // palette writes and frame starts may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_threshold(input logic [THRESH_W-1:0] value);
        drain_results();
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.threshold = value;
    endtask

    function automatic logic [CODE_W-1:0] pick_loaded_code();
        logic [CODE_W-1:0] idx;
        do
            idx = CODE_W'($urandom_range(0, PAL_DEPTH - 1));
        while (!entry_loaded[idx]);
        return idx;
    endfunction

    // Mostly frames of rows with a row mark on each first pixel; some noise mixed in.
    task random_request(output bit counted);
        int roll;
        logic [CODE_W-1:0] idx;
        logic [PAL_W-1:0] value;
        logic mark;
        roll = $urandom_range(0, 99);
        idx = CODE_W'($urandom);
        value = PAL_W'($urandom);
        mark = 1'($urandom);
        counted = 1'b1;
        if (roll < 8)
            send_request(REQ_PALETTE, idx, value, mark);
        else if (roll < 11)
        begin
            send_request(REQ_FRAME, idx, value, mark);
            // now and then the pixels after a frame start carry no row mark
            row_left = ($urandom_range(0, 3) == 0) ? 5 : 0;
        end
        else if (roll < 13)
        begin
            send_request(REQ_UNUSED, idx, value, mark);
            counted = 1'b0;
        end
        else
        begin
            if (row_left == 0)
            begin
                mark = 1'b1;
                row_left = $urandom_range(1, 16);
            end
            else
                mark = ($urandom_range(0, 99) < 3);
            row_left--;
            send_request(REQ_PIXEL, pick_loaded_code(), value, mark);
        end
    endtask

    initial
    begin
        logic [THRESH_W-1:0] phase_thresholds [PHASE_COUNT];
        int n;
        bit counted;

        board = new();
        phase_thresholds = '{THRESH_W'(256), THRESH_W'(0), THRESH_W'(255), THRESH_W'(1),
                             THRESH_W'(511), THRESH_W'(128), THRESH_W'(256), THRESH_W'(0)};
        phase_thresholds[PHASE_COUNT-1] = THRESH_W'($urandom_range(0, 511));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // threshold still at its reset value: every code replaces the color
        send_request(REQ_PALETTE, 8'd0, 16'h0000, 1'b0);
        send_request(REQ_PALETTE, 8'd255, 16'hFFFF, 1'b1);
        send_request(REQ_PALETTE, 8'd128, 16'h8001, 1'b0);
        send_request(REQ_PALETTE, 8'd127, 16'h7FFF, 1'b0);
        send_request(REQ_PIXEL, 8'd0, 16'hFFFF, 1'b1);
        send_request(REQ_PIXEL, 8'd255, 16'h0000, 1'b0);
        send_request(REQ_FRAME, 8'd255, 16'hFFFF, 1'b0);
        send_request(REQ_PIXEL, 8'd128, 16'h0000, 1'b0);
        send_request(REQ_UNUSED, 8'd255, 16'hFFFF, 1'b1);
        send_request(REQ_PIXEL, 8'd127, 16'h0000, 1'b1);

        write_threshold(THRESH_W'(128));
        send_request(REQ_PIXEL, 8'd255, 16'h0000, 1'b0);
        send_request(REQ_PIXEL, 8'd255, 16'h0000, 1'b0);
        send_request(REQ_PIXEL, 8'd128, 16'h0000, 1'b0);
        send_request(REQ_PIXEL, 8'd127, 16'h0000, 1'b0);
        send_request(REQ_PIXEL, 8'd255, 16'h0000, 1'b1);
        // read right behind the write of the same entry
        send_request(REQ_PALETTE, 8'd200, 16'h1234, 1'b0);
        send_request(REQ_PIXEL, 8'd200, 16'h0000, 1'b0);
        send_request(REQ_FRAME, 8'd0, 16'h0000, 1'b1);
        send_request(REQ_PIXEL, 8'd128, 16'h0000, 1'b1);

        write_threshold(THRESH_W'(0));
        send_request(REQ_PIXEL, 8'd0, 16'h0000, 1'b0);
        send_request(REQ_PIXEL, 8'd255, 16'h0000, 1'b0);

        // above every code: relative codes disabled
        write_threshold(THRESH_W'(511));
        send_request(REQ_PIXEL, 8'd255, 16'h0000, 1'b0);
        send_request(REQ_UNUSED, 8'd0, 16'h0000, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_threshold(phase_thresholds[p]);
            steady = (p == 3);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if (n == 40 && (p == 2 || p == 5))
                    hold_request = 1'b1;
                random_request(counted);
                if (counted)
                    n++;
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (board.pending_colors.size() != 0)
            board.report($sformatf("%0d predicted colors never came out",
                                   board.pending_colors.size()));
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
